### rtl/wgm_pkg.sv
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared constants and types for the wildcard glob matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

  localparam int MAX_PATTERN_DEF = 32;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_TEXT   = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  typedef struct packed {
    logic step;
    logic rearm;
  } cell_ctrl_t;

endpackage

### rtl/wgm_cell.sv
// ----------------------------------------------------------------------------
// wgm_cell
// One pattern position: holds its pattern byte and active bit, passes the
// star closure and the advance bit on to the next position.
// ----------------------------------------------------------------------------
module wgm_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  wgm_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          data_byte,
  input  logic                wr,
  input  logic                valid,
  input  logic                carry_in,
  input  logic                adv_in,
  output logic                closed,
  output logic                carry_out,
  output logic                adv_out
);

  logic [7:0] pat;
  logic       act;
  logic       is_star;
  logic       hit_byte;

  assign is_star   = (pat == wgm_pkg::STAR_BYTE);
  assign hit_byte  = (pat == wgm_pkg::ANY_BYTE) || (pat == data_byte);
  assign closed    = act | carry_in;
  assign carry_out = closed & valid & is_star;
  assign adv_out   = closed & valid & ~is_star & hit_byte;

  always_ff @(posedge clk) begin
    if (wr) begin
      pat <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= FIRST;
    end else if (ctrl.rearm) begin
      act <= FIRST;
    end else if (ctrl.step) begin
      act <= carry_out | adv_in;
    end
  end

endmodule

### rtl/wildcard_glob_matcher_top.sv
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_top
// Glob matcher over a row of pattern cells, one active bit per position.
// Latency: the result of an end-of-text beat is valid the cycle after it.
// Throughput: one beat per cycle unless stalled; text steps all cells at once.
// Reset: synchronous; clears length, overflow flag and result valid, and
// leaves only position zero active. Pattern bytes are not reset.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_top #(
  parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       is_match,
  output logic       pattern_overflow
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

  logic [LEN_W-1:0]       len;
  logic                   ovf;
  logic                   act_tail;
  logic                   acc;
  wgm_pkg::cell_ctrl_t    ctrl;
  logic [MAX_PATTERN-1:0] wr;
  logic [MAX_PATTERN-1:0] valid;
  logic [MAX_PATTERN-1:0] carry;
  logic [MAX_PATTERN-1:0] adv;
  logic [MAX_PATTERN-1:0] closed;
  logic [MAX_PATTERN-1:0] carry_in;
  logic [MAX_PATTERN-1:0] adv_in;
  logic                   closed_tail;
  logic                   hit;

  assign in_ready   = ~out_valid | out_ready;
  assign acc        = in_valid & in_ready;
  assign ctrl.step  = acc & (kind == wgm_pkg::KIND_TEXT);
  assign ctrl.rearm = acc & (kind != wgm_pkg::KIND_TEXT);

  assign carry_in = {carry[MAX_PATTERN-2:0], 1'b0};
  assign adv_in   = {adv[MAX_PATTERN-2:0], 1'b0};

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      valid[i] = (LEN_W'(i) < len);
      wr[i]    = acc && (kind == wgm_pkg::KIND_APPEND) && (len == LEN_W'(i));
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
      wgm_cell #(
        .FIRST(g == 0)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .data_byte(data_byte),
        .wr       (wr[g]),
        .valid    (valid[g]),
        .carry_in (carry_in[g]),
        .adv_in   (adv_in[g]),
        .closed   (closed[g]),
        .carry_out(carry[g]),
        .adv_out  (adv[g])
      );
    end
  endgenerate

  assign closed_tail = act_tail | carry[MAX_PATTERN-1];

  always_comb begin
    hit = closed_tail && (len == LEN_MAX);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      hit = hit | (closed[i] && (len == LEN_W'(i)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      ovf      <= 1'b0;
      act_tail <= 1'b0;
    end else begin
      if (ctrl.rearm) begin
        act_tail <= 1'b0;
      end else if (ctrl.step) begin
        act_tail <= adv[MAX_PATTERN-1];
      end
      if (acc && (kind == wgm_pkg::KIND_CLEAR)) begin
        len <= '0;
        ovf <= 1'b0;
      end else if (acc && (kind == wgm_pkg::KIND_APPEND)) begin
        if (len == LEN_MAX) begin
          ovf <= 1'b1;
        end else begin
          len <= len + LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc && (kind == wgm_pkg::KIND_END)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (kind == wgm_pkg::KIND_END)) begin
      is_match         <= hit & ~ovf;
      pattern_overflow <= ovf;
    end
  end

  a_ovf_no_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && pattern_overflow |-> !is_match)
    else $error("match reported with pattern overflow");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_MAX)
    else $error("pattern length beyond store");

  a_end_result: assert property (@(posedge clk) disable iff (rst)
    acc && (kind == wgm_pkg::KIND_END) |=> out_valid)
    else $error("end beat gave no result");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    acc && (kind == wgm_pkg::KIND_CLEAR) |=> (len == '0) && !ovf)
    else $error("clear did not reset pattern");

endmodule

### tb/glob_match_checker.sv
// ----------------------------------------------------------------------------
// glob_match_checker
// Watches both channels of the wildcard glob matcher, keeps its own
// bit-parallel model of the active positions and compares every verdict
// beat with the oldest predicted one, field by field.
// ----------------------------------------------------------------------------
module glob_match_checker
  import wgm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] data_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       is_match,
  input  logic       pattern_overflow,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic hit;
    logic ovf;
  } verdict_t;

  logic [7:0]           glob_bytes [MAX_PATTERN];
  int unsigned          glob_len;
  logic [MAX_PATTERN:0] live_pos;
  logic                 glob_ovf;
  verdict_t             pending_verdicts [$];
  int                   errs;

  initial begin
    fail_count = 0;
    pending    = 0;
    errs       = 0;
  end

  // a live position that holds a star also makes the one after it live
  function automatic logic [MAX_PATTERN:0] star_spread(input logic [MAX_PATTERN:0] v);
    for (int i = 0; i < glob_len; i++) begin
      if (v[i] && glob_bytes[i] == STAR_BYTE) v[i+1] = 1'b1;
    end
    return v;
  endfunction

  function automatic logic [MAX_PATTERN:0] advance_text(input logic [MAX_PATTERN:0] v,
                                                        input logic [7:0] c);
    logic [MAX_PATTERN:0] nxt;
    nxt = '0;
    v = star_spread(v);
    for (int i = 0; i < glob_len; i++) begin
      if (v[i]) begin
        if (glob_bytes[i] == STAR_BYTE) nxt[i] = 1'b1;
        else if (glob_bytes[i] == ANY_BYTE || glob_bytes[i] == c) nxt[i+1] = 1'b1;
      end
    end
    return nxt;
  endfunction

  always @(posedge clk) begin
    verdict_t             want;
    logic [MAX_PATTERN:0] closed;
    if (rst) begin
      glob_len = 0;
      glob_ovf = 1'b0;
      live_pos = {{MAX_PATTERN{1'b0}}, 1'b1};
      pending_verdicts.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict beat is_match %0b pattern_overflow %0b",
                   $time, is_match, pattern_overflow);
          errs++;
        end else begin
          want = pending_verdicts.pop_front();
          if (is_match !== want.hit) begin
            $display("%0t: is_match expected %0b actual %0b", $time, want.hit, is_match);
            errs++;
          end
          if (pattern_overflow !== want.ovf) begin
            $display("%0t: pattern_overflow expected %0b actual %0b",
                     $time, want.ovf, pattern_overflow);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (kind)
          KIND_CLEAR: begin
            glob_len = 0;
            glob_ovf = 1'b0;
            live_pos = {{MAX_PATTERN{1'b0}}, 1'b1};
          end
          KIND_APPEND: begin
            if (glob_len < MAX_PATTERN) begin
              glob_bytes[glob_len] = data_byte;
              glob_len++;
            end else begin
              glob_ovf = 1'b1;
            end
            live_pos = {{MAX_PATTERN{1'b0}}, 1'b1};
          end
          KIND_TEXT: begin
            live_pos = advance_text(live_pos, data_byte);
          end
          KIND_END: begin
            closed   = star_spread(live_pos);
            want.hit = closed[glob_len] && !glob_ovf;
            want.ovf = glob_ovf;
            pending_verdicts.push_back(want);
            live_pos = {{MAX_PATTERN{1'b0}}, 1'b1};
          end
          default: ;
        endcase
      end
    end
    fail_count <= errs;
    pending    <= pending_verdicts.size();
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives patterns and texts into the wildcard glob matcher: a directed
// opening, then random patterns with texts built to match them, some of
// them spoiled, plus stray beats. Both sides idle at random in phases, then
// a long hold-off.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wgm_pkg::*;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       out_ready = 1'b0;
  logic [1:0] kind      = KIND_CLEAR;
  logic [7:0] data_byte = 8'h00;
  logic       in_ready;
  logic       out_valid;
  logic       is_match;
  logic       pattern_overflow;
  int         fail_count;
  int         pending;

  int         snd_idle_pct = 35;
  int         rcv_idle_pct = 71;
  int         hold_len     = 0;
  int         beats_sent   = 0;
  logic [7:0] cur_glob [$];

  always #2 clk = ~clk;

  wildcard_glob_matcher_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .data_byte        (data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .is_match         (is_match),
    .pattern_overflow (pattern_overflow)
  );

  glob_match_checker i_chk (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .data_byte        (data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .is_match         (is_match),
    .pattern_overflow (pattern_overflow),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    #2_000_000;
    $display("wildcard_glob_matcher_top verification failed");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        while (hold_len > 0) begin
          @(posedge clk);
          hold_len--;
        end
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  function automatic logic [7:0] pick_glob_byte();
    int r;
    r = $urandom_range(99);
    if (r < 20) return "a";
    if (r < 40) return "b";
    if (r < 65) return STAR_BYTE;
    if (r < 80) return ANY_BYTE;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 40) return "a";
    if (r < 80) return "b";
    return 8'($urandom_range(255));
  endfunction

  task automatic send_beat(input logic [1:0] k, input logic [7:0] b);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic send_text_end(input logic [7:0] txt [$]);
    foreach (txt[i]) send_beat(KIND_TEXT, txt[i]);
    send_beat(KIND_END, 8'($urandom_range(255)));
  endtask

  task automatic load_glob();
    send_beat(KIND_CLEAR, 8'($urandom_range(255)));
    foreach (cur_glob[i]) send_beat(KIND_APPEND, cur_glob[i]);
  endtask

  task automatic drain_verdicts();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic directed_beats();
    // empty pattern against empty and non-empty text
    send_beat(KIND_END, 8'hFF);
    send_beat(KIND_TEXT, 8'h00);
    send_beat(KIND_END, 8'h00);
    // star must not commit greedily
    cur_glob = '{STAR_BYTE, "a", "b"};
    load_glob();
    send_text_end('{"a", "a", "b"});
    // pattern grows in the middle of a text
    send_beat(KIND_TEXT, "a");
    send_beat(KIND_APPEND, ANY_BYTE);
    send_text_end('{8'h00});
    // zero bytes are plain bytes
    cur_glob = '{8'h00, ANY_BYTE};
    load_glob();
    send_text_end('{8'h00, 8'hFF});
    // full store, then one byte too many
    send_beat(KIND_CLEAR, 8'h5A);
    repeat (32) send_beat(KIND_APPEND, STAR_BYTE);
    send_beat(KIND_END, 8'h00);
    send_beat(KIND_APPEND, 8'h7E);
    send_text_end('{8'h80});
    send_beat(KIND_CLEAR, 8'h00);
    send_beat(KIND_END, 8'h00);
    cur_glob.delete();
  endtask

  task automatic random_round();
    logic [7:0] txt [$];
    logic [7:0] b;
    logic [1:0] k;
    int         r;
    int         n;
    if ($urandom_range(99) < 85) begin
      r = $urandom_range(99);
      if (r < 80) n = $urandom_range(0, 6);
      else if (r < 95) n = $urandom_range(7, 32);
      else n = $urandom_range(33, 36);
      cur_glob.delete();
      repeat (n) cur_glob.push_back(pick_glob_byte());
      load_glob();
    end
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(99) < 8) begin
        k = 2'($urandom_range(3));
        b = 8'($urandom_range(255));
        send_beat(k, b);
        if (k == KIND_CLEAR) cur_glob.delete();
        else if (k == KIND_APPEND) cur_glob.push_back(b);
      end
      txt.delete();
      foreach (cur_glob[i]) begin
        if (cur_glob[i] == STAR_BYTE) repeat ($urandom_range(0, 3)) txt.push_back(pick_text_byte());
        else if (cur_glob[i] == ANY_BYTE) txt.push_back(8'($urandom_range(255)));
        else txt.push_back(cur_glob[i]);
      end
      if ($urandom_range(99) < 30) begin
        case ($urandom_range(2))
          0: if (txt.size() > 0) txt[$urandom_range(txt.size() - 1)] = pick_text_byte();
          1: txt.push_back(pick_text_byte());
          default: if (txt.size() > 0) void'(txt.pop_back());
        endcase
      end
      send_text_end(txt);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_beats();
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          snd_idle_pct = 35;
          rcv_idle_pct = 71;
        end
        1: begin
          snd_idle_pct = 71;
          rcv_idle_pct = 35;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
          hold_len     = 400;
        end
      endcase
      while (beats_sent < (ph + 1) * 550) random_round();
      drain_verdicts();
    end
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("wildcard_glob_matcher_top verification clean");
    end else begin
      $display("wildcard_glob_matcher_top verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/wgm_pkg.sv
rtl/wgm_cell.sv
rtl/wildcard_glob_matcher_top.sv
tb/glob_match_checker.sv
tb/tb_top.sv
